@@ sv/ellspmv_pkg.sv @@
// ----------------------------------------------------------------------------
// ELLPACK sparse matrix-vector multiply package
// Shared widths, reset values, codes and size defaults for the ELL SpMV block.
// ----------------------------------------------------------------------------
package ellspmv_pkg;

   localparam int VECTOR_DEPTH = 4096;
   localparam int MAX_SLOTS    = 256;
   localparam int ROW_LIMIT    = 4096;

   localparam int POSITION_W   = 12;
   localparam int DATA_W       = 32;
   localparam int ROW_W        = 12;
   localparam int SUM_W        = 64;
   localparam int SLOTS_REG_W  = 9;
   localparam int ROWS_REG_W   = 13;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 13;

   localparam logic [SLOTS_REG_W-1:0] SLOTS_RESET = 9'd32;
   localparam logic [ROWS_REG_W-1:0]  ROWS_RESET  = 13'd4096;

   typedef enum logic [0:0] {
      OP_LOAD  = 1'b0,
      OP_ENTRY = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SLOTS_PER_ROW = 1'b0,
      CSR_ROW_COUNT     = 1'b1
   } csr_index_type;

endpackage

@@ sv/ell_sparse_matrix_vector_multiply.sv @@
// ----------------------------------------------------------------------------
// ELLPACK sparse matrix-vector multiply
// A row result is offered once its last entry item has passed the stage 1
// and stage 2 registers and been accumulated into the result register.
// Throughput: one item per cycle except while a result stalls the output;
// store read, multiply and accumulate each take one stage. Load items write
// the store at acceptance. Reset clears the accumulator, counters,
// configuration registers and valid flags; the vector store is not cleared.
// ----------------------------------------------------------------------------
module ell_sparse_matrix_vector_multiply #(
   parameter int VECTOR_DEPTH = ellspmv_pkg::VECTOR_DEPTH,
   parameter int MAX_SLOTS    = ellspmv_pkg::MAX_SLOTS
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_operation,
   input  logic [ellspmv_pkg::POSITION_W-1:0]    req_vector_position,
   input  logic signed [ellspmv_pkg::DATA_W-1:0] req_vector_data,
   input  logic signed [ellspmv_pkg::DATA_W-1:0] req_matrix_value,
   input  logic [ellspmv_pkg::POSITION_W-1:0]    req_matrix_column,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ellspmv_pkg::ROW_W-1:0]         rsp_row_number,
   output logic signed [ellspmv_pkg::SUM_W-1:0]  rsp_row_sum,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ellspmv_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ellspmv_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int AW     = $clog2(VECTOR_DEPTH);
   localparam int SLOT_W = $clog2(MAX_SLOTS + 1);
   localparam int DW     = ellspmv_pkg::DATA_W;
   localparam int SW     = ellspmv_pkg::SUM_W;
   localparam int RW     = ellspmv_pkg::ROW_W;
   localparam int SRW    = ellspmv_pkg::SLOTS_REG_W;
   localparam int RRW    = ellspmv_pkg::ROWS_REG_W;

   logic [SRW-1:0] slots_reg_ff;
   logic [RRW-1:0] rows_reg_ff;

   logic           req_accept;
   logic           is_entry;
   logic [31:0]    pos_wide;
   logic [31:0]    col_wide;
   logic           ram_wr_en;
   logic           ram_rd_en;
   logic [DW-1:0]  ram_rd_data;

   logic                 s1_valid_ff;
   logic signed [DW-1:0] s1_value_ff;
   logic                 s1_col_ok_ff;
   logic                 s2_valid_ff;
   logic signed [SW-1:0] s2_product_ff;
   logic signed [DW-1:0] vec_elem;

   logic                 s1_adv;
   logic                 s2_take;
   logic                 s3_adv;

   logic signed [SW-1:0] acc_ff, acc_in;
   logic [SLOT_W-1:0]    slot_cnt_ff, slot_cnt_in;
   logic [RW-1:0]        row_ff, row_in;
   logic [SLOT_W-1:0]    eff_slots;
   logic [RRW-1:0]       eff_rows;
   logic [SLOT_W:0]      slot_next;
   logic [RRW-1:0]       row_next;
   logic                 row_done;
   logic signed [SW:0]   sum_wide;
   logic signed [SW-1:0] sum_sat;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RW-1:0]        rsp_row_ff;
   logic signed [SW-1:0] rsp_sum_ff;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         slots_reg_ff <= ellspmv_pkg::SLOTS_RESET;
         rows_reg_ff  <= ellspmv_pkg::ROWS_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (ellspmv_pkg::csr_index_type'(csr_index))
            ellspmv_pkg::CSR_SLOTS_PER_ROW: begin
               slots_reg_ff <= csr_data[SRW-1:0];
            end
            ellspmv_pkg::CSR_ROW_COUNT: begin
               rows_reg_ff <= csr_data[RRW-1:0];
            end
         endcase
      end
   end

   always_comb begin
      if (slots_reg_ff == '0) begin
         eff_slots = SLOT_W'(1);
      end else if (32'(slots_reg_ff) > MAX_SLOTS) begin
         eff_slots = SLOT_W'(MAX_SLOTS);
      end else begin
         eff_slots = SLOT_W'(slots_reg_ff);
      end
   end

   always_comb begin
      if (rows_reg_ff == '0) begin
         eff_rows = RRW'(1);
      end else if (32'(rows_reg_ff) > ellspmv_pkg::ROW_LIMIT) begin
         eff_rows = RRW'(ellspmv_pkg::ROW_LIMIT);
      end else begin
         eff_rows = rows_reg_ff;
      end
   end

   // Pipeline flow control.
   assign slot_next = {1'b0, slot_cnt_ff} + (SLOT_W + 1)'(1);
   assign row_done  = slot_next >= {1'b0, eff_slots};
   assign s3_adv    = s2_valid_ff && (!row_done || !rsp_valid_ff || rsp_ready);
   assign s2_take   = !s2_valid_ff || s3_adv;
   assign s1_adv    = s1_valid_ff && s2_take;
   assign req_ready = !s1_valid_ff || s2_take;

   assign req_accept = req_valid && req_ready;
   assign is_entry   = ellspmv_pkg::op_type'(req_operation) == ellspmv_pkg::OP_ENTRY;
   assign pos_wide   = 32'(req_vector_position);
   assign col_wide   = 32'(req_matrix_column);
   assign ram_wr_en  = req_accept && !is_entry && (pos_wide < VECTOR_DEPTH);
   assign ram_rd_en  = req_accept && is_entry;

   ellspmv_ram #(
      .WIDTH (DW),
      .DEPTH (VECTOR_DEPTH)
   ) u_vector_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (pos_wide[AW-1:0]),
      .wr_data (req_vector_data),
      .rd_en   (ram_rd_en),
      .rd_addr (col_wide[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   // Stage 1: vector element read.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid && is_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_rd_en) begin
         s1_value_ff  <= req_matrix_value;
         s1_col_ok_ff <= col_wide < VECTOR_DEPTH;
      end
   end

   // Stage 2: product.
   assign vec_elem = s1_col_ok_ff ? signed'(ram_rd_data) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_take) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_product_ff <= SW'(s1_value_ff) * SW'(vec_elem);
      end
   end

   // Stage 3: saturating accumulate and row bookkeeping.
   assign sum_wide = {acc_ff[SW-1], acc_ff} + {s2_product_ff[SW-1], s2_product_ff};
   assign row_next = {1'b0, row_ff} + RRW'(1);

   always_comb begin
      if (sum_wide[SW] != sum_wide[SW-1]) begin
         sum_sat = sum_wide[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SW-1:0];
      end
   end

   always_comb begin
      acc_in       = acc_ff;
      slot_cnt_in  = slot_cnt_ff;
      row_in       = row_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (s3_adv) begin
         if (row_done) begin
            acc_in       = '0;
            slot_cnt_in  = '0;
            row_in       = (row_next >= eff_rows) ? '0 : row_next[RW-1:0];
            rsp_valid_in = 1'b1;
         end else begin
            acc_in      = sum_sat;
            slot_cnt_in = slot_next[SLOT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         slot_cnt_ff  <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         slot_cnt_ff  <= slot_cnt_in;
         row_ff       <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_adv && row_done) begin
         rsp_row_ff <= row_ff;
         rsp_sum_ff <= sum_sat;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_row_number = rsp_row_ff;
   assign rsp_row_sum    = rsp_sum_ff;

endmodule

@@ sv/ellspmv_ram.sv @@
// ----------------------------------------------------------------------------
// ELL SpMV generic RAM
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module ellspmv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/ellspmv_checker.sv @@
// ----------------------------------------------------------------------------
// ELL SpMV port checker
// Watches the top level's ports for result ordering, output handshake and reset.
// ----------------------------------------------------------------------------
module ellspmv_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  req_valid,
   input logic                                  req_ready,
   input logic                                  req_operation,
   input logic                                  rsp_valid,
   input logic                                  rsp_ready,
   input logic [ellspmv_pkg::ROW_W-1:0]         rsp_row_number,
   input logic signed [ellspmv_pkg::SUM_W-1:0]  rsp_row_sum
);

   logic                             entry_seen_ff;
   logic                             row_seen_ff;
   logic [ellspmv_pkg::ROW_W-1:0]    last_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_seen_ff <= 1'b0;
         row_seen_ff   <= 1'b0;
         last_row_ff   <= '0;
      end else begin
         if (req_valid && req_ready && req_operation) begin
            entry_seen_ff <= 1'b1;
         end
         if (rsp_valid && rsp_ready) begin
            row_seen_ff <= 1'b1;
            last_row_ff <= rsp_row_number;
         end
      end
   end

   // A pending item holds steady until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_row_number)
         && $stable(rsp_row_sum))
      else $error("result item changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // Only entry items can complete a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> entry_seen_ff)
      else $error("result without any entry item");

   // Row numbers advance by one or wrap to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && row_seen_ff
         |-> rsp_row_number == last_row_ff + 1'b1 || rsp_row_number == '0)
      else $error("row number out of sequence");

endmodule

bind ell_sparse_matrix_vector_multiply ellspmv_checker u_ellspmv_checker (.*);
